@@ sv/byte_sum_packet_framer_defines.svh @@
// Assertion macros shared by the framer's checker.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef BYTE_SUM_PACKET_FRAMER_DEFINES_SVH
`define BYTE_SUM_PACKET_FRAMER_DEFINES_SVH

// Checked only outside reset.
`define BSPF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("framer assertion failed");

// Checked at every edge, reset included.
`define BSPF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("framer assertion failed");

`endif

@@ sv/bspf_pkg.sv @@
// Types and constants for the byte-sum packet framer.
// No dependencies; used by bspf_step, the top level and the checker.
`default_nettype none

package bspf_pkg;

    localparam logic [7:0] START_BYTE = 8'd1;
    localparam logic [7:0] END_BYTE   = 8'd92;

    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_BODY  = 1'b1;

    // Longest burst one request can cause: start, len lo, len hi, sum, end.
    localparam int unsigned BURST_MAX = 5;
    localparam int unsigned CNT_W     = $clog2(BURST_MAX + 1);

    typedef struct packed {
        logic        mode;
        logic [15:0] frame_length;
        logic [7:0]  body_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       last;
        logic       error;
    } t_out_req;

    typedef struct packed {
        logic                          open;
        logic [15:0]                   left;
        logic [7:0]                    sum;
    } t_frame_state;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0]     bytes;
        logic [CNT_W-1:0]              count;
        logic                          error;
    } t_burst;

endpackage

`default_nettype wire

@@ sv/byte_sum_packet_framer.sv @@
// Top level of the byte-sum packet framer.
// Depends on bspf_pkg and bspf_step.
//
// Usage:
//   Input channel (i_in, i_in_valid, o_in_stall): one request is either a
//   begin (mode 0, carries the frame length) or one body byte (mode 1).
//   Output channel (o_out, o_out_valid, i_out_stall): one wire byte per
//   transfer, with last marking the final byte a request caused and error
//   marking a zero length or a stray body byte.
//   A request is turned into its whole burst (1, 3 or 5 bytes) combinationally
//   and held in the burst register, which drives the output one byte a cycle unless stalled.
//   Latency: the first byte of a burst is visible the cycle after the request
//   is accepted. Throughput: one request per burst; a single-byte burst
//   (body bytes, errors) sustains one request a cycle unless the receiver
//   stalls; a begin or a closing body byte holds the input until its last
//   byte leaves the one-byte-per-cycle output port.
//   A new request is taken in the same cycle as the last byte of the current
//   burst leaves, so there are no bubbles between bursts.
//   Receiver stall: the current byte holds; the input side stalls until the
//   burst drains.
//   Reset (synchronous, active low): no frame open, checksum and count zero,
//   burst register empty.
`default_nettype none

module byte_sum_packet_framer (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire bspf_pkg::t_in_req i_in,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    output bspf_pkg::t_out_req     o_out,
    output logic                   o_out_valid,
    input  wire                    i_out_stall
);

    // frame tracking
    bspf_pkg::t_frame_state r_state;
    bspf_pkg::t_frame_state n_state;

    // burst register
    logic [bspf_pkg::BURST_MAX-1:0][7:0] r_bytes;
    logic [bspf_pkg::CNT_W-1:0]          r_cnt;
    logic [bspf_pkg::CNT_W-1:0]          r_idx;
    logic                                r_err;
    logic                                r_busy;

    bspf_pkg::t_burst w_burst;

    logic w_out_take;
    logic w_burst_end;
    logic w_in_take;
    logic w_last;

    bspf_step u_step (
        .i_req   (i_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_burst (w_burst)
    );

    assign w_last      = (r_idx == r_cnt - bspf_pkg::CNT_W'(1));
    assign w_out_take  = r_busy && !i_out_stall;
    assign w_burst_end = w_out_take && w_last;
    // free when empty or when the final byte goes this cycle
    assign o_in_stall  = r_busy && !w_burst_end;
    assign w_in_take   = i_in_valid && !o_in_stall;

    assign o_out_valid     = r_busy;
    assign o_out.wire_byte = r_bytes[r_idx];
    assign o_out.last      = w_last;
    assign o_out.error     = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_err   <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_state <= n_state;
                r_busy  <= 1'b1;
                r_cnt   <= w_burst.count;
                r_idx   <= '0;
                r_err   <= w_burst.error;
            end else if (w_burst_end) begin
                r_busy <= 1'b0;
            end else if (w_out_take) begin
                r_idx <= r_idx + bspf_pkg::CNT_W'(1);
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_bytes <= w_burst.bytes;
        end
    end

endmodule

`default_nettype wire

@@ sv/bspf_step.sv @@
// Combinational next-state and burst builder for one request.
// Depends on bspf_pkg.
`default_nettype none

module bspf_step (
    input  wire bspf_pkg::t_in_req      i_req,
    input  wire bspf_pkg::t_frame_state i_state,
    output bspf_pkg::t_frame_state      o_state,
    output bspf_pkg::t_burst            o_burst
);

    logic [7:0]  w_lo;
    logic [7:0]  w_hi;
    logic [7:0]  w_hdr_sum;
    logic [7:0]  w_body_sum;
    logic [15:0] w_left_dec;

    assign w_lo       = i_req.frame_length[7:0];
    assign w_hi       = i_req.frame_length[15:8];
    assign w_hdr_sum  = bspf_pkg::START_BYTE + w_lo + w_hi;
    assign w_body_sum = i_state.sum + i_req.body_byte;
    assign w_left_dec = i_state.left - 16'd1;

    always_comb begin
        o_state       = i_state;
        o_burst.bytes = '0;
        o_burst.count = bspf_pkg::CNT_W'(1);
        o_burst.error = 1'b0;
        if (i_req.mode == bspf_pkg::MODE_BEGIN) begin
            // any open frame is dropped without trailer
            o_state = '0;
            if (i_req.frame_length == 16'd0) begin
                o_burst.error = 1'b1;
            end else begin
                o_burst.bytes[0] = bspf_pkg::START_BYTE;
                o_burst.bytes[1] = w_lo;
                o_burst.bytes[2] = w_hi;
                if (i_req.frame_length == 16'd1) begin
                    o_burst.bytes[3] = w_hdr_sum;
                    o_burst.bytes[4] = bspf_pkg::END_BYTE;
                    o_burst.count    = bspf_pkg::CNT_W'(5);
                end else begin
                    o_burst.count = bspf_pkg::CNT_W'(3);
                    o_state.open  = 1'b1;
                    o_state.left  = i_req.frame_length - 16'd1;
                    o_state.sum   = w_hdr_sum;
                end
            end
        end else if (!i_state.open || i_state.left == 16'd0) begin
            // stray body byte: state untouched
            o_burst.error = 1'b1;
        end else begin
            o_burst.bytes[0] = i_req.body_byte;
            if (w_left_dec == 16'd0) begin
                o_burst.bytes[1] = w_body_sum;
                o_burst.bytes[2] = bspf_pkg::END_BYTE;
                o_burst.count    = bspf_pkg::CNT_W'(3);
                o_state          = '0;
            end else begin
                o_state.left = w_left_dec;
                o_state.sum  = w_body_sum;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/bspf_checker.sv @@
// Port-level checks for the byte-sum packet framer, bound to the top level.
// Depends on bspf_pkg and byte_sum_packet_framer_defines.svh.
`default_nettype none
`include "byte_sum_packet_framer_defines.svh"

module bspf_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire bspf_pkg::t_in_req  i_in,
    input wire                     i_in_valid,
    input wire                     o_in_stall,
    input wire bspf_pkg::t_out_req o_out,
    input wire                     o_out_valid,
    input wire                     i_out_stall
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // every request yields at least one byte
    `BSPF_ASSERT(a_req_gives_byte, i_clk, i_rst_n, w_in_acc |=> o_out_valid)

    // a rejected request is a single zero byte
    `BSPF_ASSERT(a_err_single, i_clk, i_rst_n, o_out_valid && o_out.error |-> o_out.last && (o_out.wire_byte == 8'd0))

    // a stalled byte stays on the port
    `BSPF_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))

    // reset empties the output
    `BSPF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind byte_sum_packet_framer bspf_checker u_bspf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in        (i_in),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out       (o_out),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
